FILE: rtl/core/ilsd_pkg.sv
// Shared constants, codes and types for the interrupt level source dispatch block.
package ilsd_pkg;

    localparam int MAX_SOURCES  = 96;
    localparam int WORD_W       = 32;
    localparam int NUM_WORDS    = 3;
    localparam int FIELD_W      = 4;
    localparam int FIELDS_PER_WORD = 8;
    localparam int DEV_W        = 7;
    localparam int LEVEL_W      = 4;
    localparam int CFG_W        = 4;

    localparam logic [FIELD_W-1:0] MAX_FIELD    = 4'd8;
    localparam logic [LEVEL_W:0]   LEVEL_OFFSET = 5'd7;

    localparam logic [CFG_W-1:0] HW_ERROR_LEVEL_RST   = 4'd5;
    localparam logic [CFG_W-1:0] CORE_TIMER_LEVEL_RST = 4'd6;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_ENABLE   = 2'd1,
        CMD_DISPATCH = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_DEVICE   = 3'd1,
        KIND_HW_ERROR = 3'd2,
        KIND_TIMER    = 3'd3,
        KIND_RAISE    = 3'd4
    } kind_t;

    typedef enum logic {
        CFG_HW_ERROR_LEVEL   = 1'b0,
        CFG_CORE_TIMER_LEVEL = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic             found;
        logic [DEV_W-1:0] dev;
    } sel_t;

endpackage

FILE: rtl/core/ilsd_select.sv
// Candidate match and fixed priority pick of the dispatched source.
module ilsd_select
    import ilsd_pkg::*;
#(
    parameter int NUM_SOURCES = MAX_SOURCES
)
(
    input  logic [LEVEL_W-1:0]                level,
    input  logic [NUM_WORDS-1:0][WORD_W-1:0]  pending,
    input  logic [NUM_WORDS-1:0][WORD_W-1:0]  enables,
    input  logic [FIELD_W-1:0]                fields [NUM_SOURCES],
    output sel_t                              sel
);

    logic [NUM_WORDS-1:0][WORD_W-1:0] cand;
    logic [NUM_WORDS-1:0]             word_hit;
    logic [NUM_WORDS-1:0][4:0]        word_bit;

    always_comb
    begin
        for (int s = 0; s < MAX_SOURCES; s++)
        begin
            if (s < NUM_SOURCES)
            begin
                cand[s / WORD_W][s % WORD_W] =
                    (fields[s] <= MAX_FIELD)
                    && (({1'b0, fields[s]} + LEVEL_OFFSET) == {1'b0, level})
                    && pending[s / WORD_W][s % WORD_W]
                    && enables[s / WORD_W][s % WORD_W];
            end
            else
            begin
                cand[s / WORD_W][s % WORD_W] = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            word_hit[w] = |cand[w];
            word_bit[w] = 5'd0;
            for (int b = 0; b < WORD_W; b++)
            begin
                if (cand[w][b])
                begin
                    word_bit[w] = 5'(b);
                end
            end
        end
    end

    always_comb
    begin
        sel.found = 1'b0;
        sel.dev   = '0;
        for (int w = NUM_WORDS - 1; w >= 0; w--)
        begin
            if (word_hit[w])
            begin
                sel.found = 1'b1;
                sel.dev   = DEV_W'(w * WORD_W) + {2'b00, word_bit[w]};
            end
        end
    end

endmodule

FILE: rtl/core/interrupt_level_source_dispatch.sv
// Top level of the interrupt level source dispatch block.
//
//  Channel   Direction  Handshake            Contents
//  in        input      in_valid/in_ready    cmd, word_index, assign_value, source_number,
//                                            level, pending_low/mid/high
//  out       output     out_valid/out_ready  status, kind, device_number, enables_low/mid/high
//  cfg       input      cfg_write            cfg_index, cfg_data
//
// One word is accepted per cycle while in_ready is high; each word is held in the input register,
// and its result in the result register. These two registers bound a single pass of match and pick logic.
// Reset clears both valid flags and the enable words and sets the level registers to
// their reset values; level fields hold no value until loaded. A stalled result holds the
// result register and, once the input register is also full, in_ready drops.
module interrupt_level_source_dispatch
    import ilsd_pkg::*;
#(
    parameter int NUM_SOURCES = MAX_SOURCES
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [3:0]          word_index,
    input  logic [31:0]         assign_value,
    input  logic [7:0]          source_number,
    input  logic [3:0]          level,
    input  logic [31:0]         pending_low,
    input  logic [31:0]         pending_mid,
    input  logic [31:0]         pending_high,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                status,
    output logic [2:0]          kind,
    output logic [6:0]          device_number,
    output logic [31:0]         enables_low,
    output logic [31:0]         enables_mid,
    output logic [31:0]         enables_high,

    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_data
);

    localparam int ALL_W = NUM_WORDS * WORD_W;

    logic                             s1_valid_reg;
    logic [1:0]                       s1_cmd_reg;
    logic [3:0]                       s1_widx_reg;
    logic [31:0]                      s1_aval_reg;
    logic [7:0]                       s1_srcno_reg;
    logic [LEVEL_W-1:0]               s1_level_reg;
    logic [NUM_WORDS-1:0][WORD_W-1:0] s1_pend_reg;

    logic                             out_valid_reg;
    logic                             status_reg;
    kind_t                            kind_reg;
    logic [DEV_W-1:0]                 dev_reg;

    logic [ALL_W-1:0]                 en_reg;
    logic [ALL_W-1:0]                 en_next;
    logic [CFG_W-1:0]                 hw_error_level_reg;
    logic [CFG_W-1:0]                 core_timer_level_reg;
    logic [FIELD_W-1:0]               fields_reg [NUM_SOURCES];

    logic                             s1_advance;
    logic                             status_next;
    kind_t                            kind_next;
    logic [DEV_W-1:0]                 dev_next;
    sel_t                             sel;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg     <= cmd;
            s1_widx_reg    <= word_index;
            s1_aval_reg    <= assign_value;
            s1_srcno_reg   <= source_number;
            s1_level_reg   <= level;
            s1_pend_reg[0] <= pending_low;
            s1_pend_reg[1] <= pending_mid;
            s1_pend_reg[2] <= pending_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_error_level_reg   <= HW_ERROR_LEVEL_RST;
            core_timer_level_reg <= CORE_TIMER_LEVEL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HW_ERROR_LEVEL:   hw_error_level_reg   <= cfg_data;
                CFG_CORE_TIMER_LEVEL: core_timer_level_reg <= cfg_data;
                default:              hw_error_level_reg   <= hw_error_level_reg;
            endcase
        end
    end

    // Level fields carry no reset; a load covers eight consecutive sources.
    always_ff @(posedge clk)
    begin
        if (s1_advance && (s1_cmd_reg == CMD_LOAD))
        begin
            for (int s = 0; s < NUM_SOURCES; s++)
            begin
                if (4'(s / FIELDS_PER_WORD) == s1_widx_reg)
                begin
                    fields_reg[s] <= s1_aval_reg[FIELD_W * (s % FIELDS_PER_WORD) +: FIELD_W];
                end
            end
        end
    end

    ilsd_select #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_select (
        .level   (s1_level_reg),
        .pending (s1_pend_reg),
        .enables (en_reg),
        .fields  (fields_reg),
        .sel     (sel)
    );

    always_comb
    begin
        en_next     = en_reg;
        status_next = 1'b0;
        kind_next   = KIND_NONE;
        dev_next    = '0;
        case (s1_cmd_reg)
            CMD_ENABLE:
            begin
                if (s1_srcno_reg < 8'(NUM_SOURCES))
                begin
                    en_next = en_reg | (ALL_W'(1) << s1_srcno_reg);
                end
                else
                begin
                    status_next = 1'b1;
                end
            end
            CMD_DISPATCH:
            begin
                if (sel.found)
                begin
                    kind_next = KIND_DEVICE;
                    dev_next  = sel.dev;
                end
                else if (s1_level_reg == hw_error_level_reg)
                begin
                    kind_next = KIND_HW_ERROR;
                end
                else if (s1_level_reg == core_timer_level_reg)
                begin
                    kind_next = KIND_TIMER;
                end
                else
                begin
                    kind_next = KIND_RAISE;
                end
            end
            default:
            begin
                en_next = en_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                en_reg        <= en_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
            dev_reg    <= dev_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign kind          = kind_reg;
    assign device_number = dev_reg;
    assign enables_low   = en_reg[0 * WORD_W +: WORD_W];
    assign enables_mid   = en_reg[1 * WORD_W +: WORD_W];
    assign enables_high  = en_reg[2 * WORD_W +: WORD_W];

endmodule

FILE: rtl/core/ilsd_checker.sv
// Port-level assertions for the interrupt level source dispatch block, with its bind.
module ilsd_checker
    import ilsd_pkg::*;
#(
    parameter int NUM_SOURCES = MAX_SOURCES
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic [2:0]  kind,
    input logic [6:0]  device_number,
    input logic [31:0] enables_low,
    input logic [31:0] enables_mid,
    input logic [31:0] enables_high
);

    logic [95:0] en_all;

    assign en_all = {enables_high, enables_mid, enables_low};

    // Only a device dispatch names a source.
    a_dev_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_DEVICE) |-> (device_number == '0))
        else $error("device number set without a device dispatch");

    // A rejected enable never dispatches.
    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> (kind == KIND_NONE))
        else $error("bad parameter status with a dispatch kind");

    // The chosen source is in range and enabled.
    a_dev_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DEVICE)
        |-> (device_number < 7'(NUM_SOURCES)) && en_all[device_number])
        else $error("dispatched source is not enabled");

    // Enables only ever accumulate from one delivered word to the next.
    a_en_grow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid
        |-> ((en_all & $past(en_all)) == $past(en_all)))
        else $error("an enable bit was cleared");

endmodule

bind interrupt_level_source_dispatch ilsd_checker #(
    .NUM_SOURCES (NUM_SOURCES)
) u_ilsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .kind          (kind),
    .device_number (device_number),
    .enables_low   (enables_low),
    .enables_mid   (enables_mid),
    .enables_high  (enables_high)
);

FILE: test/interrupt_level_source_dispatch_test.sv
// Self-checking testbench for the interrupt level source dispatch block.
`timescale 1ns / 1ps

module interrupt_level_source_dispatch_test;
    import ilsd_pkg::*;

    localparam int NUM_SOURCES = MAX_SOURCES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [3:0]  word_index;
        logic [31:0] assign_value;
        logic [7:0]  source_number;
        logic [3:0]  level;
        logic [31:0] pending_low;
        logic [31:0] pending_mid;
        logic [31:0] pending_high;
    } in_word_t;

    typedef struct {
        logic        status;
        kind_t       kind;
        logic [6:0]  device_number;
        logic [31:0] enables_low;
        logic [31:0] enables_mid;
        logic [31:0] enables_high;
    } out_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = '0;
    logic [3:0]  word_index = '0;
    logic [31:0] assign_value = '0;
    logic [7:0]  source_number = '0;
    logic [3:0]  level = '0;
    logic [31:0] pending_low = '0;
    logic [31:0] pending_mid = '0;
    logic [31:0] pending_high = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        status;
    logic [2:0]  kind;
    logic [6:0]  device_number;
    logic [31:0] enables_low;
    logic [31:0] enables_mid;
    logic [31:0] enables_high;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [3:0]  cfg_data = '0;

    in_word_t  word_queue[$];
    out_word_t awaited_results[$];
    out_word_t front_result;
    in_word_t  front_word;

    logic [3:0]  level_fields [NUM_SOURCES];
    logic [31:0] enable_words [3];
    logic [3:0]  hw_error_cfg = HW_ERROR_LEVEL_RST;
    logic [3:0]  core_timer_cfg = CORE_TIMER_LEVEL_RST;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    logic hold_trigger = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    interrupt_level_source_dispatch DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .word_index(word_index), .assign_value(assign_value),
        .source_number(source_number), .level(level),
        .pending_low(pending_low), .pending_mid(pending_mid), .pending_high(pending_high),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .kind(kind), .device_number(device_number),
        .enables_low(enables_low), .enables_mid(enables_mid), .enables_high(enables_high),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch in %s: got %h, want %h", what, got, want);
        mismatch_count++;
    endtask

    // Applies one accepted word to the shadow state and queues the result it causes.
    task automatic resolve_word(input in_word_t w);
        out_word_t   r;
        logic [31:0] pend [3];
        logic [31:0] cand;
        logic        found;
        int          f;
        int          top_bit;
        r.status = 1'b0;
        r.kind = KIND_NONE;
        r.device_number = '0;
        pend[0] = w.pending_low;
        pend[1] = w.pending_mid;
        pend[2] = w.pending_high;
        case (w.cmd)
            CMD_LOAD:
            begin
                if (w.word_index <= 11)
                begin
                    for (int i = 0; i < FIELDS_PER_WORD; i++)
                    begin
                        level_fields[w.word_index * FIELDS_PER_WORD + i] =
                            w.assign_value[4 * i +: 4];
                    end
                end
            end
            CMD_ENABLE:
            begin
                if (w.source_number >= NUM_SOURCES)
                    r.status = 1'b1;
                else
                    enable_words[w.source_number[6:5]][w.source_number[4:0]] = 1'b1;
            end
            CMD_DISPATCH:
            begin
                found = 1'b0;
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    if (!found)
                    begin
                        cand = '0;
                        for (int b = 0; b < WORD_W; b++)
                        begin
                            f = level_fields[i * WORD_W + b];
                            if (f <= MAX_FIELD && f + LEVEL_OFFSET == w.level)
                                cand[b] = 1'b1;
                        end
                        cand = cand & pend[i] & enable_words[i];
                        if (cand != 0)
                        begin
                            top_bit = 0;
                            for (int b = 0; b < WORD_W; b++)
                            begin
                                if (cand[b])
                                    top_bit = b;
                            end
                            found = 1'b1;
                            r.kind = KIND_DEVICE;
                            r.device_number = 7'(i * WORD_W + top_bit);
                        end
                    end
                end
                if (!found)
                begin
                    if (w.level == hw_error_cfg)
                        r.kind = KIND_HW_ERROR;
                    else if (w.level == core_timer_cfg)
                        r.kind = KIND_TIMER;
                    else
                        r.kind = KIND_RAISE;
                end
            end
            default:
            begin
            end
        endcase
        r.enables_low = enable_words[0];
        r.enables_mid = enable_words[1];
        r.enables_high = enable_words[2];
        awaited_results.push_back(r);
    endtask

    function automatic in_word_t make_word(input logic [1:0] c, input logic [3:0] idx,
                                           input logic [31:0] val, input logic [7:0] src,
                                           input logic [3:0] lvl, input logic [31:0] p0,
                                           input logic [31:0] p1, input logic [31:0] p2);
        in_word_t w;
        w.cmd = c;
        w.word_index = idx;
        w.assign_value = val;
        w.source_number = src;
        w.level = lvl;
        w.pending_low = p0;
        w.pending_mid = p1;
        w.pending_high = p2;
        return w;
    endfunction

    function automatic logic [31:0] rand_pending();
        case ($urandom_range(5, 0))
            0: return 32'h0;
            1: return $urandom();
            2: return $urandom() & $urandom() & $urandom();
            3: return 32'h1 << $urandom_range(31, 0);
            default: return $urandom() & $urandom();
        endcase
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        int       pick;
        w = make_word(2'($urandom_range(3, 0)), 4'($urandom_range(15, 0)), $urandom(),
                      8'($urandom_range(255, 0)), 4'($urandom_range(15, 0)),
                      rand_pending(), rand_pending(), rand_pending());
        pick = $urandom_range(99, 0);
        if (pick < 20)
        begin
            w.cmd = CMD_LOAD;
            if ($urandom_range(99, 0) < 85)
                w.word_index = 4'($urandom_range(11, 0));
            for (int i = 0; i < FIELDS_PER_WORD; i++)
            begin
                if ($urandom_range(99, 0) < 75)
                    w.assign_value[4 * i +: 4] = 4'($urandom_range(8, 0));
            end
        end
        else if (pick < 26)
        begin
            w.cmd = CMD_ENABLE;
            if ($urandom_range(99, 0) < 75)
                w.source_number = 8'($urandom_range(NUM_SOURCES - 1, 0));
        end
        else if (pick < 96)
        begin
            w.cmd = CMD_DISPATCH;
            if ($urandom_range(99, 0) < 70)
                w.level = 4'($urandom_range(15, 7));
        end
        else
        begin
            w.cmd = CMD_UNUSED;
        end
        return w;
    endfunction

    // Sender: offers queued words and predicts each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                resolve_word(make_word(cmd, word_index, assign_value, source_number, level,
                                       pending_low, pending_mid, pending_high));
            end
            if (!in_valid || in_ready)
            begin
                if (word_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    front_word = word_queue.pop_front();
                    in_valid <= 1'b1;
                    cmd <= front_word.cmd;
                    word_index <= front_word.word_index;
                    assign_value <= front_word.assign_value;
                    source_number <= front_word.source_number;
                    level <= front_word.level;
                    pending_low <= front_word.pending_low;
                    pending_mid <= front_word.pending_mid;
                    pending_high <= front_word.pending_high;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing into a full block.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_trigger)
            hold_left <= HOLD_CYCLES;
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_left > 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result with no word waiting", {29'b0, kind}, 32'b0);
            end
            else
            begin
                front_result = awaited_results.pop_front();
                if (status !== front_result.status)
                    report_mismatch("status", 32'(status), 32'(front_result.status));
                if (kind !== front_result.kind)
                    report_mismatch("kind", 32'(kind), 32'(front_result.kind));
                if (device_number !== front_result.device_number)
                    report_mismatch("device_number", 32'(device_number),
                                    32'(front_result.device_number));
                if (enables_low !== front_result.enables_low)
                    report_mismatch("enables_low", enables_low, front_result.enables_low);
                if (enables_mid !== front_result.enables_mid)
                    report_mismatch("enables_mid", enables_mid, front_result.enables_mid);
                if (enables_high !== front_result.enables_high)
                    report_mismatch("enables_high", enables_high, front_result.enables_high);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_idle();
        while (word_queue.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_levels(input logic [3:0] hw_level, input logic [3:0] timer_level);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_HW_ERROR_LEVEL;
        cfg_data <= hw_level;
        hw_error_cfg = hw_level;
        @(posedge clk);
        cfg_index <= CFG_CORE_TIMER_LEVEL;
        cfg_data <= timer_level;
        core_timer_cfg = timer_level;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input logic [3:0] hw_level, input logic [3:0] timer_level,
                             input int send_pct, input int recv_pct, input int count,
                             input bit hold);
        wait_idle();
        write_levels(hw_level, timer_level);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
        begin
            @(posedge clk);
            hold_trigger <= 1'b1;
            @(posedge clk);
            hold_trigger <= 1'b0;
        end
        for (int i = 0; i < count; i++)
            word_queue.push_back(rand_word());
        while (word_queue.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SOURCES; i++)
            level_fields[i] = '0;
        for (int i = 0; i < NUM_WORDS; i++)
            enable_words[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every level field is loaded before the first dispatch.
        word_queue.push_back(make_word(CMD_LOAD, 4'd0, 32'h0000_0000, 8'd0, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_LOAD, 4'd1, 32'hffff_ffff, 8'hff, 4'hf,
                                       32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        word_queue.push_back(make_word(CMD_LOAD, 4'd2, 32'h8888_8888, 8'd0, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_LOAD, 4'd3, 32'h9999_9999, 8'd0, 4'd0, 0, 0, 0));
        for (int i = 4; i < 11; i++)
            word_queue.push_back(make_word(CMD_LOAD, 4'(i), $urandom(), 8'd0, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_LOAD, 4'd11, 32'h8000_0000, 8'd0, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_LOAD, 4'd15, 32'h1234_5678, 8'd0, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_UNUSED, 4'd5, 32'hffff_ffff, 8'd3, 4'd7,
                                       32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        word_queue.push_back(make_word(CMD_ENABLE, 4'd0, 32'h0, 8'd0, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_ENABLE, 4'd0, 32'h0, 8'd95, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_ENABLE, 4'd0, 32'h0, 8'd96, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_ENABLE, 4'd0, 32'h0, 8'd255, 4'd0, 0, 0, 0));
        word_queue.push_back(make_word(CMD_DISPATCH, 4'd0, 32'h0, 8'd0, 4'd7,
                                       32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        word_queue.push_back(make_word(CMD_DISPATCH, 4'd0, 32'h0, 8'd0, 4'd15,
                                       32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        word_queue.push_back(make_word(CMD_DISPATCH, 4'd0, 32'h0, 8'd0, 4'd15, 0, 0, 0));
        word_queue.push_back(make_word(CMD_DISPATCH, 4'd0, 32'h0, 8'd0, 4'd5, 0, 0, 0));
        word_queue.push_back(make_word(CMD_DISPATCH, 4'd0, 32'h0, 8'd0, 4'd6, 0, 0, 0));
        word_queue.push_back(make_word(CMD_DISPATCH, 4'd0, 32'h0, 8'd0, 4'd0,
                                       32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        while (word_queue.size() != 0)
            @(posedge clk);

        run_phase(4'd5, 4'd6, 0, 0, 275, 1'b0);
        run_phase(4'd0, 4'd15, 61, 0, 275, 1'b0);
        run_phase(4'd15, 4'd0, 0, 61, 275, 1'b0);
        run_phase(4'd7, 4'd7, 7, 7, 275, 1'b0);
        run_phase(4'd9, 4'd12, 0, 0, 275, 1'b1);
        run_phase(4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)), 7, 7, 275, 1'b0);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0 && word_queue.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ilsd_pkg.sv
rtl/core/ilsd_select.sv
rtl/core/interrupt_level_source_dispatch.sv
rtl/core/ilsd_checker.sv
test/interrupt_level_source_dispatch_test.sv
